// ----- src/mexp_pkg.sv -----
// Shared constants for the modular exponentiation block.
// No dependencies; imported by every module of the block.
package mexp_pkg;

  localparam int FIELD_W        = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int EXP_WIDTH_DEF  = 32;

  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd10007;

endpackage

// ----- src/mexp_mulmod.sv -----
// Shared modular multiplier: MSB-first shift-add with reduction, one
// multiplier bit per cycle. Depends on mexp_pkg for its default width.
module mexp_mulmod #(
  parameter int DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [DATA_WIDTH-1:0] x,
  input  logic [DATA_WIDTH-1:0] y,
  input  logic [DATA_WIDTH-1:0] m,
  output logic [DATA_WIDTH-1:0] prod,
  output logic                  done
);
  import mexp_pkg::*;

  localparam int SW = DATA_WIDTH + 2;
  localparam int CW = $clog2(DATA_WIDTH);

  logic                  run;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH-1:0] xr;
  logic [DATA_WIDTH-1:0] yr;
  logic [DATA_WIDTH-1:0] r;
  logic [DATA_WIDTH-1:0] r_next;

  logic [SW-1:0] sum;
  logic [SW-1:0] m1;
  logic [SW-1:0] m2;

  // r < m and x < m (or x == 1) keep the sum below 3m: at most two subtracts.
  // m == 0 means no reduction, plain truncating product.
  always_comb begin
    sum = {1'b0, r, 1'b0} + (yr[DATA_WIDTH-1] ? {2'b00, xr} : '0);
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    if (m == '0) begin
      r_next = sum[DATA_WIDTH-1:0];
    end else if (sum >= m2) begin
      r_next = DATA_WIDTH'(sum - m2);
    end else if (sum >= m1) begin
      r_next = DATA_WIDTH'(sum - m1);
    end else begin
      r_next = sum[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(DATA_WIDTH - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r  <= '0;
      xr <= x;
      yr <= y;
    end else if (run) begin
      r  <= r_next;
      yr <= yr << 1;
    end
  end

  assign prod = r;

endmodule

// ----- src/mexp_seq.sv -----
// Square-and-multiply sequencer: holds accumulator, square and exponent,
// and drives the shared mexp_mulmod unit. Depends on mexp_pkg.
module mexp_seq #(
  parameter int DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEF,
  parameter int EXP_WIDTH  = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] base_in,
  input  logic [EXP_WIDTH-1:0]  exp_in,
  input  logic [DATA_WIDTH-1:0] m,
  output logic                  busy,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);
  import mexp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_NEXT   = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQR    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   go;
  logic   go_next;

  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] sq;
  logic [EXP_WIDTH-1:0]  e;

  logic [DATA_WIDTH-1:0] ux;
  logic [DATA_WIDTH-1:0] uy;
  logic [DATA_WIDTH-1:0] uprod;
  logic                  udone;

  mexp_mulmod #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .x    (ux),
    .y    (uy),
    .m    (m),
    .prod (uprod),
    .done (udone)
  );

  // Operand select; the base pass reduces base as base * 1 mod m.
  always_comb begin
    case (state)
      S_REDUCE: begin
        ux = DATA_WIDTH'(1);
        uy = sq;
      end
      S_MUL: begin
        ux = acc;
        uy = sq;
      end
      default: begin
        ux = sq;
        uy = sq;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    go_next    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (exp_in == '0) begin
            state_next = S_DONE;
          end else if (m == '0) begin
            state_next = S_NEXT;
          end else begin
            state_next = S_REDUCE;
            go_next    = 1'b1;
          end
        end
      end
      S_REDUCE: begin
        if (udone) state_next = S_NEXT;
      end
      S_NEXT: begin
        // e is never zero here
        go_next    = 1'b1;
        state_next = e[0] ? S_MUL : S_SQR;
      end
      S_MUL: begin
        if (udone) begin
          if (e[EXP_WIDTH-1:1] == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SQR;
            go_next    = 1'b1;
          end
        end
      end
      S_SQR: begin
        if (udone) state_next = S_NEXT;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      go    <= go_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          acc <= DATA_WIDTH'(1);
          sq  <= base_in;
          e   <= exp_in;
        end
      end
      S_REDUCE: begin
        if (udone) sq <= uprod;
      end
      S_MUL: begin
        if (udone) acc <= uprod;
      end
      S_SQR: begin
        if (udone) begin
          sq <= uprod;
          e  <= e >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  assign result = acc;

endmodule

// ----- src/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: modulus register and
// command ports around mexp_seq. Depends on mexp_pkg, mexp_seq, mexp_mulmod.
//
// Usage: pulse start with base and exponent while busy is low; the beat is
// taken at that edge and busy rises. When the result is ready, done is high
// for exactly one cycle with power_mod valid; busy is still high in that
// cycle and drops in the next, where a new start may be taken. The receiver
// cannot stall. The modulus is written over its own channel
// (modulus_valid/modulus_ready); ready is high while the block is idle and no
// start is offered. Reset loads modulus 10007 and returns the sequencer to
// idle; no result is pending after reset.
// Exponent zero gives done in the cycle after the start beat. Otherwise each
// multiplication runs on the shared shift-add unit, one bit a cycle; an item
// needs one base reduction (skipped for modulus zero), one multiply per set
// exponent bit, one square per exponent bit below the top set bit and one
// S_NEXT step per bit to pick the next step. One item at a time: a new start
// is taken only once busy has dropped.
module modular_exponentiation #(
  parameter int DATA_WIDTH = mexp_pkg::DATA_WIDTH_DEF,
  parameter int EXP_WIDTH  = mexp_pkg::EXP_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [mexp_pkg::FIELD_W-1:0] base,
  input  logic [mexp_pkg::FIELD_W-1:0] exponent,
  output logic                         done,
  output logic [mexp_pkg::FIELD_W-1:0] power_mod,
  input  logic                         modulus_valid,
  output logic                         modulus_ready,
  input  logic [mexp_pkg::FIELD_W-1:0] modulus
);
  import mexp_pkg::*;

  logic [FIELD_W-1:0]    modulus_q;
  logic [DATA_WIDTH-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_q <= MODULUS_RESET;
    end else if (modulus_valid && modulus_ready) begin
      modulus_q <= modulus;
    end
  end

  // a start beat takes the modulus as it stands; no write at that edge
  assign modulus_ready = !busy && !start;

  mexp_seq #(
    .DATA_WIDTH(DATA_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .base_in (base[DATA_WIDTH-1:0]),
    .exp_in  (EXP_WIDTH'(exponent)),
    .m       (modulus_q[DATA_WIDTH-1:0]),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  assign power_mod = FIELD_W'(result);

endmodule

// ----- bench/tb_modular_exponentiation.sv -----
// Self-checking bench for modular_exponentiation: directed and random beats
// under several modulus settings, checked against a square-and-multiply model.
// Depends on mexp_pkg and the modular_exponentiation RTL.
module tb_modular_exponentiation;
  import mexp_pkg::*;

  typedef enum bit {JOB_POWER, JOB_MODULUS} job_kind_t;

  typedef struct {
    job_kind_t          kind;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] value;
  } job_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [FIELD_W-1:0] base = '0;
  logic [FIELD_W-1:0] exponent = '0;
  logic               done;
  logic [FIELD_W-1:0] power_mod;
  logic               modulus_valid = 1'b0;
  logic               modulus_ready;
  logic [FIELD_W-1:0] modulus = '0;

  job_t               job_q[$];
  logic [FIELD_W-1:0] power_q[$];
  logic [FIELD_W-1:0] modulus_shadow = MODULUS_RESET;

  int n_sent = 0;
  int n_taken = 0;
  int n_mod_sent = 0;
  int n_mod_taken = 0;
  int n_results = 0;
  int n_fail = 0;
  int gap_left = 0;

  modular_exponentiation dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .base          (base),
    .exponent      (exponent),
    .done          (done),
    .power_mod     (power_mod),
    .modulus_valid (modulus_valid),
    .modulus_ready (modulus_ready),
    .modulus       (modulus)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // modulus zero means no reduction: the product wraps at the field width
  function automatic logic [FIELD_W-1:0] mul_mod(logic [FIELD_W-1:0] x,
                                                 logic [FIELD_W-1:0] y,
                                                 logic [FIELD_W-1:0] m);
    logic [2*FIELD_W-1:0] p;
    p = {{FIELD_W{1'b0}}, x} * {{FIELD_W{1'b0}}, y};
    if (m == '0)
      return p[FIELD_W-1:0];
    return FIELD_W'(p % {{FIELD_W{1'b0}}, m});
  endfunction

  // right-to-left; base is not reduced up front, exponent zero gives 1
  function automatic logic [FIELD_W-1:0] power_of(logic [FIELD_W-1:0] b,
                                                  logic [FIELD_W-1:0] e,
                                                  logic [FIELD_W-1:0] m);
    logic [FIELD_W-1:0] acc;
    logic [FIELD_W-1:0] sq;
    logic [FIELD_W-1:0] rest;
    acc = 1;
    sq = b;
    rest = e;
    while (rest != '0) begin
      if (rest[0])
        acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic void push_power(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e);
    job_t j;
    j.kind = JOB_POWER;
    j.base = b;
    j.exponent = e;
    j.value = '0;
    job_q.push_back(j);
  endfunction

  function automatic void push_modulus(logic [FIELD_W-1:0] m);
    job_t j;
    j.kind = JOB_MODULUS;
    j.base = '0;
    j.exponent = '0;
    j.value = m;
    job_q.push_back(j);
  endfunction

  // driver: one beat at a time; modulus writes wait for the block to drain
  always @(negedge clk) begin : drive_proc
    bit   nxt_start;
    bit   nxt_valid;
    job_t j;
    if (rst) begin
      start <= 1'b0;
      modulus_valid <= 1'b0;
    end else if ((start && n_taken != n_sent) ||
                 (modulus_valid && n_mod_taken != n_mod_sent)) begin
      // beat still offered
    end else begin
      nxt_start = 1'b0;
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (job_q.size() != 0) begin
        j = job_q[0];
        if (j.kind == JOB_MODULUS) begin
          if (power_q.size() == 0 && !busy) begin
            nxt_valid = 1'b1;
            modulus <= j.value;
            void'(job_q.pop_front());
            n_mod_sent++;
            gap_left = $urandom_range(0, 19);
          end
        end else begin
          nxt_start = 1'b1;
          base <= j.base;
          exponent <= j.exponent;
          void'(job_q.pop_front());
          n_sent++;
          // every fourth run of 16 beats goes back to back
          gap_left = ((n_sent / 16) % 4 == 0) ? 0 : $urandom_range(0, 19);
        end
      end
      start <= nxt_start;
      modulus_valid <= nxt_valid;
    end
  end

  // monitor: results are checked before a beat taken at the same edge is queued
  always @(posedge clk) begin : watch_proc
    logic [FIELD_W-1:0] want;
    if (rst) begin
      modulus_shadow = MODULUS_RESET;
    end else begin
      if (done) begin
        n_results++;
        if (power_q.size() == 0) begin
          $error("power_mod: no result expected, got %08h", power_mod);
          n_fail++;
        end else begin
          want = power_q.pop_front();
          if (power_mod !== want) begin
            $error("power_mod: expected %08h, got %08h", want, power_mod);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        power_q.push_back(power_of(base, exponent, modulus_shadow));
        n_taken++;
      end
      if (modulus_valid && modulus_ready) begin
        modulus_shadow = modulus;
        n_mod_taken++;
      end
    end
  end

  initial begin : stim_proc
    logic [FIELD_W-1:0] m;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] e;
    logic [FIELD_W-1:0] mask;
    int len;
    int pick;

    // reset modulus, exponent zero, base at and above the modulus
    push_power(32'd0, 32'd0);
    push_power(32'd0, 32'd1);
    push_power(32'd1, 32'd0);
    push_power(32'hFFFF_FFFF, 32'd0);
    push_power(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_power(32'd10007, 32'd5);
    push_power(32'd10008, 32'd3);
    push_power(32'hFFFF_FFFF, 32'd1);
    push_power(32'd2, 32'hFFFF_FFFF);
    push_power(32'd12345, 32'h8000_0000);
    push_power(32'd3, 32'd10006);
    push_modulus(32'd1);
    push_power(32'd5, 32'd0);
    push_power(32'd5, 32'd7);
    push_power(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_modulus(32'hFFFF_FFFF);
    push_power(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push_power(32'hFFFF_FFFF, 32'd2);
    push_power(32'h8000_0000, 32'd3);
    // modulus zero: products wrap instead of being reduced
    push_modulus(32'd0);
    push_power(32'd3, 32'd40);
    push_power(32'hFFFF_FFFF, 32'd3);
    push_power(32'h0001_0000, 32'd2);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: m = ($urandom == 0) ? 32'd1 : $urandom;
        1: m = $urandom_range(2, 1000);
        2: m = 32'hFFFF_FFFF;
        3: m = 32'd1;
        4: m = {1'b1, 31'($urandom)};
        5: m = $urandom_range(2, 65535);
        6: m = 32'd0;
        default: m = MODULUS_RESET;
      endcase
      push_modulus(m);
      for (int i = 0; i < 34; i++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0)
          b = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        else if (pick == 1 && m > 1)
          b = m - 1 + $urandom_range(0, 2);
        else
          b = $urandom;
        // exponent length is drawn evenly from 0 to 32 bits so the run stays fast
        len = $urandom_range(0, 32);
        mask = (len == 32) ? '1 : ((32'd1 << len) - 1);
        e = $urandom & mask;
        if (len > 0)
          e[len-1] = 1'b1;
        push_power(b, e);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (job_q.size() != 0 || n_taken != n_sent || n_mod_taken != n_mod_sent ||
           power_q.size() != 0)
      @(posedge clk);
    // long enough for a stray result to show up
    repeat (2200) @(posedge clk);

    $display("Checked %0d results from %0d beats across %0d modulus writes", n_results,
             n_taken, n_mod_taken);
    $display("Covered exponent zero, modulus one and zero, all-ones fields, base >= modulus");
    if (n_fail == 0 && power_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin : limit_proc
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- modular_exponentiation.f -----
src/mexp_pkg.sv
src/mexp_mulmod.sv
src/mexp_seq.sv
src/modular_exponentiation.sv
bench/tb_modular_exponentiation.sv
